// ===== hdl/sega_pkg.sv =====
// Package of the segment allocator: table sizes, field widths, codes and types.
// Used by every module of the allocator; depends on nothing.
package sega_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int REGION_BYTES  = 2097152;
    localparam int ADDR_W        = 21;
    localparam int SIZE_W        = 22;
    localparam int COUNT_W       = 22;
    localparam int NEED_W        = COUNT_W + 3;
    localparam int PID_W         = 8;
    localparam int HDL_W         = 8;

    localparam logic [1:0] FN_CREATE = 2'd0;
    localparam logic [1:0] FN_ALLOC  = 2'd1;
    localparam logic [1:0] FN_FREE   = 2'd2;
    localparam logic [1:0] FN_TERM   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic              is_free;
        logic [PID_W-1:0]  pid;
        logic [HDL_W-1:0]  handle;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } seg_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        seg_t             wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // Element size as a left shift: char 1, short 2, int 4, double 8, long 8, else 4.
    function automatic logic [1:0] elem_shift(input logic [2:0] etype);
        logic [1:0] sh;
        case (etype)
            3'd1:    sh = 2'd0;
            3'd2:    sh = 2'd1;
            3'd3:    sh = 2'd2;
            3'd4:    sh = 2'd3;
            3'd5:    sh = 2'd3;
            default: sh = 2'd2;
        endcase
        return sh;
    endfunction

endpackage

// ===== hdl/segment_allocator_coalescing_top.sv =====
// Top level of the segment allocator: stream ports, sequencer and segment table memory.
// Depends on sega_pkg, sega_ctrl and sega_mem.
//
// The block keeps one segment table of 64 entries shared by all processes, each entry
// a free segment or an allocated variable of one process. One operation is taken per
// transfer on the input stream (create, allocate, free, terminate) and exactly one
// result transfer comes back for it, carrying a status code and the segment's address
// and size. Operations run one at a time. Every operation makes one pass over the table
// memory, one entry per cycle through its registered read port, followed by a decision
// and write-back; a successful free makes a second pass to merge neighboring free space.
// A finished result sits in an output register, so the next operation is accepted while
// the result still waits to be taken. Validity of the entries is kept in flip-flops that
// reset clears, so no clearing pass follows reset.
module segment_allocator_coalescing_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // proc_id[7:0], handle[15:8], elem_type[18:16],
                                   // elem_count[40:19], zeros above
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // seg_addr[20:0], seg_bytes[42:21], zeros above
    output logic [2:0]  m_tuser    // status
);
    import sega_pkg::*;

    mem_req_t          mreq;
    seg_t              mrdata;
    logic [ADDR_W-1:0] seg_addr;
    logic [SIZE_W-1:0] seg_bytes;

    sega_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_pid     (s_tdata[7:0]),
        .in_handle  (s_tdata[15:8]),
        .in_etype   (s_tdata[18:16]),
        .in_count   (s_tdata[40:19]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_addr   (seg_addr),
        .out_bytes  (seg_bytes),
        .mreq       (mreq),
        .mrdata     (mrdata)
    );

    sega_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (mrdata)
    );

    // Result fields packed from the lowest bit up; the top bits stay zero.
    assign m_tdata = {5'd0, seg_bytes, seg_addr};

endmodule

// ===== hdl/sega_mem.sv =====
// Segment table storage: one write port and one read port with registered read data.
// Depends on sega_pkg for the entry and request types.
module sega_mem (
    input  logic              clk,
    input  sega_pkg::mem_req_t req,
    output sega_pkg::seg_t     rdata
);
    import sega_pkg::*;

    seg_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ===== hdl/sega_ctrl.sv =====
// Sequencer of the segment allocator: table scans, decisions, write-back and result register.
// Depends on sega_pkg; drives the table memory in sega_mem.
module sega_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_func,
    input  logic [sega_pkg::PID_W-1:0] in_pid,
    input  logic [sega_pkg::HDL_W-1:0] in_handle,
    input  logic [2:0]                 in_etype,
    input  logic [sega_pkg::COUNT_W-1:0] in_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 out_status,
    output logic [sega_pkg::ADDR_W-1:0] out_addr,
    output logic [sega_pkg::SIZE_W-1:0] out_bytes,
    output sega_pkg::mem_req_t         mreq,
    input  sega_pkg::seg_t             mrdata
);
    import sega_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN1  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SPLIT  = 3'd3;
    localparam logic [2:0] S_SCAN2  = 3'd4;
    localparam logic [2:0] S_MERGE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [2:0]               state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     pv_reg;
    logic [IDX_W-1:0]         pidx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [1:0]        func_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [HDL_W-1:0]  handle_reg;
    logic [NEED_W-1:0] need_reg;

    logic              exists_reg, inv_found_reg, var_found_reg, best_found_reg;
    logic [IDX_W-1:0]  inv_idx_reg, var_idx_reg, best_idx_reg;
    logic [ADDR_W-1:0] best_addr_reg, v_addr_reg;
    logic [SIZE_W-1:0] best_size_reg, v_size_reg;

    logic [2:0]        res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [SIZE_W-1:0] res_bytes_reg;
    logic              ovalid_reg;
    logic [2:0]        ostatus_reg;
    logic [ADDR_W-1:0] oaddr_reg;
    logic [SIZE_W-1:0] obytes_reg;

    logic              ev, pid_hit, var_hit, fit_hit, scan_last, out_load;
    logic [SIZE_W-1:0] e_end, v_end;

    logic [2:0]        dec_status;
    logic [ADDR_W-1:0] dec_addr;
    logic [SIZE_W-1:0] dec_bytes;
    logic [2:0]        dec_state;
    logic              dec_mark;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_addr   = oaddr_reg;
    assign out_bytes  = obytes_reg;

    assign ev        = valid_reg[pidx_reg];
    assign pid_hit   = ev && (mrdata.pid == pid_reg);
    assign var_hit   = pid_hit && !mrdata.is_free && (mrdata.handle == handle_reg);
    assign fit_hit   = pid_hit && mrdata.is_free
                       && ({{(NEED_W-SIZE_W){1'b0}}, mrdata.size} >= need_reg)
                       && (!best_found_reg || mrdata.addr < best_addr_reg);
    assign e_end     = {1'b0, mrdata.addr} + mrdata.size;
    assign v_end     = {1'b0, v_addr_reg} + v_size_reg;
    assign scan_last = pv_reg && (pidx_reg == LAST_IDX);
    assign out_load  = (state_reg == S_DONE) && (!ovalid_reg || out_ready);

    // Memory requests: reads walk the table during scans, writes happen in single states.
    always_comb
    begin
        mreq        = '0;
        mreq.raddr  = cnt_reg[IDX_W-1:0];
        case (state_reg)
            S_DECIDE:
            begin
                if (func_reg == FN_CREATE && !exists_reg && inv_found_reg)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = inv_idx_reg;
                    mreq.wdata = '{1'b1, pid_reg, '0, '0, SIZE_W'(REGION_BYTES)};
                end
                else if (func_reg == FN_ALLOC && exists_reg && !var_found_reg
                         && need_reg != '0 && best_found_reg)
                begin
                    if ({{(NEED_W-SIZE_W){1'b0}}, best_size_reg} == need_reg)
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = best_idx_reg;
                        mreq.wdata = '{1'b0, pid_reg, handle_reg, best_addr_reg, best_size_reg};
                    end
                    else if (inv_found_reg)
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = inv_idx_reg;
                        mreq.wdata = '{1'b0, pid_reg, handle_reg, best_addr_reg,
                                       need_reg[SIZE_W-1:0]};
                    end
                end
            end
            S_SPLIT:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = best_idx_reg;
                mreq.wdata = '{1'b1, pid_reg, '0, best_addr_reg + need_reg[ADDR_W-1:0],
                               best_size_reg - need_reg[SIZE_W-1:0]};
            end
            S_MERGE:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = var_idx_reg;
                mreq.wdata = '{1'b1, pid_reg, '0, v_addr_reg, v_size_reg};
            end
            default:
            begin
                mreq.we = 1'b0;
            end
        endcase
    end

    // Outcome of an operation once the first scan has gathered its facts.
    always_comb
    begin
        dec_status = ST_OK;
        dec_addr   = '0;
        dec_bytes  = '0;
        dec_state  = S_DONE;
        dec_mark   = 1'b0;
        case (func_reg)
            FN_CREATE:
            begin
                if (exists_reg)
                begin
                    dec_status = ST_DUP;
                end
                else if (!inv_found_reg)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_mark  = 1'b1;
                    dec_bytes = SIZE_W'(REGION_BYTES);
                end
            end
            FN_ALLOC:
            begin
                if (!exists_reg)
                begin
                    dec_status = ST_UNKNOWN;
                end
                else if (var_found_reg)
                begin
                    dec_status = ST_DUP;
                end
                else if (need_reg == '0 || !best_found_reg)
                begin
                    dec_status = ST_NOFIT;
                end
                else if ({{(NEED_W-SIZE_W){1'b0}}, best_size_reg} == need_reg)
                begin
                    dec_addr  = best_addr_reg;
                    dec_bytes = best_size_reg;
                end
                else if (!inv_found_reg)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_mark  = 1'b1;
                    dec_addr  = best_addr_reg;
                    dec_bytes = need_reg[SIZE_W-1:0];
                    dec_state = S_SPLIT;
                end
            end
            FN_FREE:
            begin
                if (!var_found_reg)
                begin
                    dec_status = ST_UNKNOWN;
                end
                else
                begin
                    dec_addr  = v_addr_reg;
                    dec_bytes = v_size_reg;
                    dec_state = S_SCAN2;
                end
            end
            default:
            begin
                if (!exists_reg)
                begin
                    dec_status = ST_UNKNOWN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            valid_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            // Read pipeline shared by both scans.
            if (state_reg == S_SCAN1 || state_reg == S_SCAN2)
            begin
                pv_reg   <= (cnt_reg < CNT_W'(TABLE_ENTRIES));
                pidx_reg <= cnt_reg[IDX_W-1:0];
                if (cnt_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg       <= in_func;
                        pid_reg        <= in_pid;
                        handle_reg     <= in_handle;
                        need_reg       <= NEED_W'(in_count) << elem_shift(in_etype);
                        exists_reg     <= 1'b0;
                        inv_found_reg  <= 1'b0;
                        var_found_reg  <= 1'b0;
                        best_found_reg <= 1'b0;
                        cnt_reg        <= '0;
                        pv_reg         <= 1'b0;
                        state_reg      <= S_SCAN1;
                    end
                end
                S_SCAN1:
                begin
                    if (pv_reg)
                    begin
                        if (!ev && !inv_found_reg)
                        begin
                            inv_found_reg <= 1'b1;
                            inv_idx_reg   <= pidx_reg;
                        end
                        if (pid_hit)
                        begin
                            exists_reg <= 1'b1;
                            if (func_reg == FN_TERM)
                            begin
                                valid_reg[pidx_reg] <= 1'b0;
                            end
                        end
                        if (var_hit && !var_found_reg)
                        begin
                            var_found_reg <= 1'b1;
                            var_idx_reg   <= pidx_reg;
                            v_addr_reg    <= mrdata.addr;
                            v_size_reg    <= mrdata.size;
                        end
                        if (fit_hit)
                        begin
                            best_found_reg <= 1'b1;
                            best_idx_reg   <= pidx_reg;
                            best_addr_reg  <= mrdata.addr;
                            best_size_reg  <= mrdata.size;
                        end
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    res_status_reg <= dec_status;
                    res_addr_reg   <= dec_addr;
                    res_bytes_reg  <= dec_bytes;
                    state_reg      <= dec_state;
                    if (dec_mark)
                    begin
                        valid_reg[inv_idx_reg] <= 1'b1;
                    end
                    if (dec_state == S_SCAN2)
                    begin
                        cnt_reg <= '0;
                        pv_reg  <= 1'b0;
                    end
                end
                S_SPLIT:
                begin
                    state_reg <= S_DONE;
                end
                S_SCAN2:
                begin
                    // Merge free neighbors into the segment being released.
                    if (pv_reg && pid_hit && mrdata.is_free && pidx_reg != var_idx_reg)
                    begin
                        if (e_end == {1'b0, v_addr_reg})
                        begin
                            v_addr_reg          <= mrdata.addr;
                            v_size_reg          <= v_size_reg + mrdata.size;
                            valid_reg[pidx_reg] <= 1'b0;
                        end
                        else if (v_end == {1'b0, mrdata.addr})
                        begin
                            v_size_reg          <= v_size_reg + mrdata.size;
                            valid_reg[pidx_reg] <= 1'b0;
                        end
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_MERGE;
                    end
                end
                S_MERGE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        ostatus_reg <= res_status_reg;
                        oaddr_reg   <= res_addr_reg;
                        obytes_reg  <= res_bytes_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/sega_checker.sv =====
// Port-level checks of the segment allocator, bound to its top level.
// Depends only on the top level's ports.
module sega_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Operations run one at a time: an accepted transfer closes the input.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation is running");

    // Only defined status codes appear.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= 3'd4)
        else $error("undefined status code");

    // A failed operation reports no segment.
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 3'd0 |-> m_tdata == 48'd0)
        else $error("failed operation carries a segment");

endmodule

bind segment_allocator_coalescing_top sega_checker u_sega_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
